// File: sv/spmc_pkg.sv
// spmc_pkg: shared types, codes and constants of the signal pending/mask controller
// depends on nothing; imported by every module of the block

package spmc_pkg;

   localparam int MASK_W            = 64;
   localparam int SIG_W             = 6;
   localparam int ADDR_W            = 64;
   localparam int NUM_SIGNALS_DEF   = 64;
   localparam int CONTEXT_BYTES_DEF = 88;
   localparam int FRAME_GAP         = 16;

   localparam logic [SIG_W-1:0]  SIG_KILL = SIG_W'(9);
   localparam logic [SIG_W-1:0]  SIG_STOP = SIG_W'(19);
   localparam logic [MASK_W-1:0] UNBLOCKABLE =
      (MASK_W'(1) << SIG_KILL) | (MASK_W'(1) << SIG_STOP);
   // CHLD CONT STOP TSTP TTIN TTOU URG WINCH IO
   localparam logic [MASK_W-1:0] DEFAULT_IGNORE_SET = MASK_W'(64'h0000_0000_30FE_0000);
   localparam logic [ADDR_W-1:0] FRAME_ALIGN = ~ADDR_W'(64'hF);
   localparam logic [7:0]        EXIT_BASE   = 8'd128;
   localparam logic [ADDR_W-1:0] HANDLER_DEFAULT = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] HANDLER_IGNORE  = ADDR_W'(1);

   localparam int FLAG_NODEFER   = 0;
   localparam int FLAG_RESETHAND = 1;

   typedef enum logic [2:0] {
      ACT_SEND        = 3'd0,
      ACT_DELIVER     = 3'd1,
      ACT_BLOCK       = 3'd2,
      ACT_UNBLOCK     = 3'd3,
      ACT_SET_MASK    = 3'd4,
      ACT_WRITE_ENTRY = 3'd5,
      ACT_READ_ENTRY  = 3'd6,
      ACT_RESTORE     = 3'd7
   } act_type;

   typedef enum logic [1:0] {
      OUT_NOTHING   = 2'd0,
      OUT_IGNORED   = 2'd1,
      OUT_TERMINATE = 2'd2,
      OUT_HANDLER   = 2'd3
   } outcome_type;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] handler;
      logic [ADDR_W-1:0] restorer;
      logic [MASK_W-1:0] hmask;
      logic [1:0]        flags;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [SIG_W-1:0] addr;
      entry_type        data;
   } mem_wr_type;

endpackage

// File: sv/spmc_action_mem.sv
// spmc_action_mem: per-signal action table, one synchronous memory with registered read
// depends on spmc_pkg; per-entry valid bits make unwritten entries read as zero

module spmc_action_mem
   import spmc_pkg::*;
#(
   parameter int NUM_SIGNALS = NUM_SIGNALS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [SIG_W-1:0] rd_addr,
   input  mem_wr_type       wr,
   output entry_type        rd_data
);

   localparam int IDX_W = $clog2(NUM_SIGNALS);

   entry_type  mem [NUM_SIGNALS];
   logic       entry_valid_ff [NUM_SIGNALS];
   entry_type  rd_data_ff;
   logic       rd_valid_ff;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;

   assign rd_idx = rd_addr[IDX_W-1:0];
   assign wr_idx = wr.addr[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_idx] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= entry_valid_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SIGNALS; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (wr.en) begin
         entry_valid_ff[wr_idx] <= 1'b1;
      end
   end

   // never-written entries stand for the all-zero default action
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: sv/spmc_pick.sv
// spmc_pick: registered lowest-set-bit search over the pending and unblocked set
// depends on spmc_pkg; two-level search, byte group first then bit within it

module spmc_pick
   import spmc_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [MASK_W-1:0] ready,
   output logic              found,
   output logic [SIG_W-1:0]  sig
);

   localparam int GROUPS = MASK_W / 8;
   localparam int GRP_W  = $clog2(GROUPS);

   logic [GROUPS-1:0] grp_any;
   logic [GRP_W-1:0]  grp;
   logic [7:0]        grp_bits;
   logic [2:0]        bit_sel;
   logic              found_ff;
   logic              found_in;
   logic [SIG_W-1:0]  sig_ff;
   logic [SIG_W-1:0]  sig_in;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any[g] = |ready[g*8 +: 8];
      end
      grp = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp = GRP_W'(g);
         end
      end
      grp_bits = ready[{grp, 3'b000} +: 8];
      bit_sel  = '0;
      for (int b = 7; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = 3'(b);
         end
      end
      found_in = |grp_any;
      sig_in   = SIG_W'({grp, bit_sel});
   end

   always_ff @(posedge clock) begin
      if (load) begin
         found_ff <= found_in;
         sig_ff   <= sig_in;
      end
   end

   assign found = found_ff;
   assign sig   = sig_ff;

endmodule

// File: sv/signal_pending_mask_controller.sv
// signal_pending_mask_controller: top level, sequencer, signal sets and result registers
// depends on spmc_pkg, spmc_pick and spmc_action_mem
//
//   channel   ports                    handshake
//   request   start, busy, req_*       taken at an edge with start high and busy low
//   response  rsp_valid, rsp_*         one-cycle strobe, taken at the edge ending it
//
// an item passes through idle (accept), read (action table read) and exec (execute and write back);
// the result strobe follows in the cycle after execute, when the next item can be taken.
// the read state is there because the action table memory has a registered read.
// reset clears the sets, the kill flag and the table valid bits at once.
// responses cannot be stalled, so no skid storage is needed.

module signal_pending_mask_controller
   import spmc_pkg::*;
#(
   parameter int NUM_SIGNALS   = NUM_SIGNALS_DEF,
   parameter int CONTEXT_BYTES = CONTEXT_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_action,
   input  logic [SIG_W-1:0]  req_signal_number,
   input  logic [MASK_W-1:0] req_mask_in,
   input  logic [ADDR_W-1:0] req_handler_in,
   input  logic [ADDR_W-1:0] req_restorer_in,
   input  logic              req_nodefer_in,
   input  logic              req_resethand_in,
   input  logic              req_task_waiting,
   input  logic              req_task_is_user,
   input  logic [ADDR_W-1:0] req_user_stack,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [1:0]        rsp_outcome,
   output logic [SIG_W-1:0]  rsp_chosen_signal,
   output logic              rsp_wake_task,
   output logic [ADDR_W-1:0] rsp_handler_out,
   output logic [ADDR_W-1:0] rsp_restorer_out,
   output logic [MASK_W-1:0] rsp_mask_out,
   output logic [1:0]        rsp_flags_out,
   output logic [ADDR_W-1:0] rsp_frame_stack,
   output logic [7:0]        rsp_exit_code,
   output logic [MASK_W-1:0] rsp_blocked_now,
   output logic              rsp_kill_requested
);

   localparam logic [ADDR_W-1:0] FRAME_DROP = ADDR_W'(FRAME_GAP + CONTEXT_BYTES);
   localparam logic [SIG_W:0]    SIG_LIMIT  = (SIG_W+1)'(NUM_SIGNALS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [MASK_W-1:0] pending_ff, pending_in;
   logic [MASK_W-1:0] blocked_ff, blocked_in;
   logic              kill_ff, kill_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // latched request
   act_type           act_ff;
   logic [SIG_W-1:0]  sig_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [ADDR_W-1:0] handler_ff;
   logic [ADDR_W-1:0] restorer_ff;
   logic              nodefer_ff;
   logic              resethand_ff;
   logic              waiting_ff;
   logic              is_user_ff;
   logic [ADDR_W-1:0] stack_ff;

   // result registers
   logic              status_ff, status_in;
   outcome_type       outcome_ff, outcome_in;
   logic [SIG_W-1:0]  chosen_ff, chosen_in;
   logic              wake_ff, wake_in;
   logic [ADDR_W-1:0] hout_ff, hout_in;
   logic [ADDR_W-1:0] rout_ff, rout_in;
   logic [MASK_W-1:0] mout_ff, mout_in;
   logic [1:0]        fout_ff, fout_in;
   logic [ADDR_W-1:0] frame_ff, frame_in;
   logic [7:0]        exit_ff, exit_in;

   logic              accept;
   logic              pick_found;
   logic [SIG_W-1:0]  pick_sig;
   logic [SIG_W-1:0]  rd_sig;
   logic [SIG_W-1:0]  rd_addr;
   logic              rd_en;
   entry_type         entry;
   mem_wr_type        wr;

   logic              sig_valid;
   logic              entry_ok;
   logic [MASK_W-1:0] strip;
   logic [MASK_W-1:0] sig_bit;
   logic [MASK_W-1:0] pick_bit;
   logic [7:0]        pick_exit;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   spmc_pick u_pick (
      .clock (clock),
      .load  (accept),
      .ready (pending_ff & ~blocked_ff),
      .found (pick_found),
      .sig   (pick_sig)
   );

   assign rd_en   = (state_ff == ST_READ);
   assign rd_sig  = (act_ff == ACT_DELIVER) ? pick_sig : sig_ff;
   // keep the address inside the table for out-of-range signal numbers
   assign rd_addr = ({1'b0, rd_sig} < SIG_LIMIT) ? rd_sig : '0;

   spmc_action_mem #(
      .NUM_SIGNALS (NUM_SIGNALS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (entry)
   );

   assign sig_valid = (sig_ff != '0) && ({1'b0, sig_ff} < SIG_LIMIT);
   assign entry_ok  = sig_valid && (sig_ff != SIG_KILL) && (sig_ff != SIG_STOP);
   assign strip     = mask_ff & ~UNBLOCKABLE;
   assign sig_bit   = MASK_W'(1) << sig_ff;
   assign pick_bit  = MASK_W'(1) << pick_sig;
   assign pick_exit = EXIT_BASE + 8'(pick_sig);

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      blocked_in   = blocked_ff;
      kill_in      = kill_ff;
      rsp_valid_in = 1'b0;
      status_in    = STATUS_OK;
      outcome_in   = OUT_NOTHING;
      chosen_in    = '0;
      wake_in      = 1'b0;
      hout_in      = '0;
      rout_in      = '0;
      mout_in      = '0;
      fout_in      = '0;
      frame_in     = '0;
      exit_in      = '0;
      wr           = '0;
      wr.addr      = rd_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (act_ff)
               ACT_SEND: begin
                  if (!sig_valid) begin
                     status_in = STATUS_INVALID;
                  end else begin
                     pending_in = pending_ff | sig_bit;
                     if (sig_ff == SIG_KILL) begin
                        kill_in = 1'b1;
                     end
                     wake_in = waiting_ff && ((sig_ff == SIG_KILL) || !blocked_ff[sig_ff]);
                  end
               end
               ACT_DELIVER: begin
                  if (is_user_ff && pick_found) begin
                     chosen_in  = pick_sig;
                     pending_in = pending_ff & ~pick_bit;
                     if (pick_sig == SIG_KILL || entry.handler == HANDLER_DEFAULT) begin
                        if (pick_sig != SIG_KILL && DEFAULT_IGNORE_SET[pick_sig]) begin
                           outcome_in = OUT_IGNORED;
                        end else begin
                           outcome_in = OUT_TERMINATE;
                           exit_in    = pick_exit;
                        end
                     end else if (entry.handler == HANDLER_IGNORE) begin
                        outcome_in = OUT_IGNORED;
                     end else if (entry.restorer == '0) begin
                        outcome_in = OUT_TERMINATE;
                        exit_in    = pick_exit;
                     end else begin
                        outcome_in = OUT_HANDLER;
                        hout_in    = entry.handler;
                        rout_in    = entry.restorer;
                        mout_in    = blocked_ff;
                        frame_in   = (stack_ff - FRAME_DROP) & FRAME_ALIGN;
                        blocked_in = blocked_ff | entry.hmask |
                                     (entry.flags[FLAG_NODEFER] ? '0 : pick_bit);
                        // one-shot handler falls back to the default action
                        if (entry.flags[FLAG_RESETHAND]) begin
                           wr.en           = 1'b1;
                           wr.data         = entry;
                           wr.data.handler = HANDLER_DEFAULT;
                        end
                     end
                  end
               end
               ACT_BLOCK: begin
                  mout_in    = blocked_ff;
                  blocked_in = blocked_ff | strip;
               end
               ACT_UNBLOCK: begin
                  mout_in    = blocked_ff;
                  blocked_in = blocked_ff & ~strip;
               end
               ACT_SET_MASK, ACT_RESTORE: begin
                  mout_in    = blocked_ff;
                  blocked_in = strip;
               end
               ACT_WRITE_ENTRY, ACT_READ_ENTRY: begin
                  if (!entry_ok) begin
                     status_in = STATUS_INVALID;
                  end else begin
                     hout_in = entry.handler;
                     rout_in = entry.restorer;
                     mout_in = entry.hmask;
                     fout_in = entry.flags;
                     if (act_ff == ACT_WRITE_ENTRY) begin
                        wr.en            = 1'b1;
                        wr.data.handler  = handler_ff;
                        wr.data.restorer = restorer_ff;
                        wr.data.hmask    = strip;
                        wr.data.flags    = {resethand_ff, nodefer_ff};
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         blocked_ff   <= '0;
         kill_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         blocked_ff   <= blocked_in;
         kill_ff      <= kill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff       <= act_type'(req_action);
         sig_ff       <= req_signal_number;
         mask_ff      <= req_mask_in;
         handler_ff   <= req_handler_in;
         restorer_ff  <= req_restorer_in;
         nodefer_ff   <= req_nodefer_in;
         resethand_ff <= req_resethand_in;
         waiting_ff   <= req_task_waiting;
         is_user_ff   <= req_task_is_user;
         stack_ff     <= req_user_stack;
      end
      if (state_ff == ST_EXEC) begin
         status_ff  <= status_in;
         outcome_ff <= outcome_in;
         chosen_ff  <= chosen_in;
         wake_ff    <= wake_in;
         hout_ff    <= hout_in;
         rout_ff    <= rout_in;
         mout_ff    <= mout_in;
         fout_ff    <= fout_in;
         frame_ff   <= frame_in;
         exit_ff    <= exit_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_chosen_signal  = chosen_ff;
   assign rsp_wake_task      = wake_ff;
   assign rsp_handler_out    = hout_ff;
   assign rsp_restorer_out   = rout_ff;
   assign rsp_mask_out       = mout_ff;
   assign rsp_flags_out      = fout_ff;
   assign rsp_frame_stack    = frame_ff;
   assign rsp_exit_code      = exit_ff;
   assign rsp_blocked_now    = blocked_ff;
   assign rsp_kill_requested = kill_ff;

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for signal_pending_mask_controller
// depends on spmc_pkg and the signal_pending_mask_controller rtl; reads no files

module tb;
   import spmc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 500;

   typedef struct packed {
      act_type           action;
      logic [SIG_W-1:0]  sig;
      logic [MASK_W-1:0] mask;
      logic [ADDR_W-1:0] handler;
      logic [ADDR_W-1:0] restorer;
      logic              nodefer;
      logic              resethand;
      logic              waiting;
      logic              is_user;
      logic [ADDR_W-1:0] stack;
   } sig_req_type;

   typedef struct packed {
      logic              status;
      outcome_type       outcome;
      logic [SIG_W-1:0]  chosen;
      logic              wake;
      logic [ADDR_W-1:0] handler;
      logic [ADDR_W-1:0] restorer;
      logic [MASK_W-1:0] mask;
      logic [1:0]        flags;
      logic [ADDR_W-1:0] frame;
      logic [7:0]        term_code;
      logic [MASK_W-1:0] blocked;
      logic              kill;
   } sig_rsp_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [2:0]        req_action;
   logic [SIG_W-1:0]  req_signal_number;
   logic [MASK_W-1:0] req_mask_in;
   logic [ADDR_W-1:0] req_handler_in;
   logic [ADDR_W-1:0] req_restorer_in;
   logic              req_nodefer_in;
   logic              req_resethand_in;
   logic              req_task_waiting;
   logic              req_task_is_user;
   logic [ADDR_W-1:0] req_user_stack;
   logic              rsp_valid;
   logic              rsp_status;
   logic [1:0]        rsp_outcome;
   logic [SIG_W-1:0]  rsp_chosen_signal;
   logic              rsp_wake_task;
   logic [ADDR_W-1:0] rsp_handler_out;
   logic [ADDR_W-1:0] rsp_restorer_out;
   logic [MASK_W-1:0] rsp_mask_out;
   logic [1:0]        rsp_flags_out;
   logic [ADDR_W-1:0] rsp_frame_stack;
   logic [7:0]        rsp_exit_code;
   logic [MASK_W-1:0] rsp_blocked_now;
   logic              rsp_kill_requested;

   // predicted controller state
   logic [MASK_W-1:0] pend_model;
   logic [MASK_W-1:0] blk_model;
   logic              kill_seen;
   logic [ADDR_W-1:0] act_handler  [64];
   logic [ADDR_W-1:0] act_restorer [64];
   logic [MASK_W-1:0] act_hmask    [64];
   logic [1:0]        act_flags    [64];

   sig_rsp_type awaited_rsp[$];
   int fail_count   = 0;
   int items_sent   = 0;
   int rsp_checked  = 0;
   int quiet_cycles = 0;
   int n_handler = 0, n_terminate = 0, n_ignored = 0, n_wake = 0;

   signal_pending_mask_controller u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_signal_number  (req_signal_number),
      .req_mask_in        (req_mask_in),
      .req_handler_in     (req_handler_in),
      .req_restorer_in    (req_restorer_in),
      .req_nodefer_in     (req_nodefer_in),
      .req_resethand_in   (req_resethand_in),
      .req_task_waiting   (req_task_waiting),
      .req_task_is_user   (req_task_is_user),
      .req_user_stack     (req_user_stack),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_outcome        (rsp_outcome),
      .rsp_chosen_signal  (rsp_chosen_signal),
      .rsp_wake_task      (rsp_wake_task),
      .rsp_handler_out    (rsp_handler_out),
      .rsp_restorer_out   (rsp_restorer_out),
      .rsp_mask_out       (rsp_mask_out),
      .rsp_flags_out      (rsp_flags_out),
      .rsp_frame_stack    (rsp_frame_stack),
      .rsp_exit_code      (rsp_exit_code),
      .rsp_blocked_now    (rsp_blocked_now),
      .rsp_kill_requested (rsp_kill_requested)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // works out the response of one item and advances the predicted state
   function automatic sig_rsp_type apply_signal_item(input sig_req_type r);
      sig_rsp_type       o;
      logic [MASK_W-1:0] strip;
      logic [MASK_W-1:0] ready;
      logic [MASK_W-1:0] bit_s;
      logic [SIG_W-1:0]  s;
      logic [SIG_W-1:0]  pick;
      o     = '0;
      s     = r.sig;
      strip = r.mask & ~UNBLOCKABLE;
      case (r.action)
         ACT_SEND: begin
            if (s == 0) begin
               o.status = STATUS_INVALID;
            end else begin
               pend_model[s] = 1'b1;
               if (r.sig == SIG_KILL) kill_seen = 1'b1;
               if (r.waiting && (r.sig == SIG_KILL || !blk_model[s])) begin
                  o.wake = 1'b1;
                  n_wake++;
               end
            end
         end
         ACT_DELIVER: begin
            ready = pend_model & ~blk_model;
            if (r.is_user && ready != '0) begin
               pick = '0;
               while (pick < 63 && !ready[pick]) pick++;
               if (pick == 0) begin
                  pend_model &= ~ready;
               end else begin
                  bit_s = MASK_W'(1) << pick;
                  o.chosen = pick;
                  pend_model &= ~bit_s;
                  if (o.chosen == SIG_KILL || act_handler[pick] == HANDLER_DEFAULT) begin
                     if (o.chosen != SIG_KILL && DEFAULT_IGNORE_SET[pick]) begin
                        o.outcome = OUT_IGNORED;
                     end else begin
                        o.outcome   = OUT_TERMINATE;
                        o.term_code = EXIT_BASE + 8'(pick);
                     end
                  end else if (act_handler[pick] == HANDLER_IGNORE) begin
                     o.outcome = OUT_IGNORED;
                  end else if (act_restorer[pick] == '0) begin
                     o.outcome   = OUT_TERMINATE;
                     o.term_code = EXIT_BASE + 8'(pick);
                  end else begin
                     o.outcome  = OUT_HANDLER;
                     o.handler  = act_handler[pick];
                     o.restorer = act_restorer[pick];
                     o.mask     = blk_model;
                     o.frame    = (r.stack - ADDR_W'(FRAME_GAP + CONTEXT_BYTES_DEF))
                                  & FRAME_ALIGN;
                     blk_model |= act_hmask[pick];
                     if (!act_flags[pick][FLAG_NODEFER]) blk_model |= bit_s;
                     if (act_flags[pick][FLAG_RESETHAND]) act_handler[pick] = HANDLER_DEFAULT;
                  end
                  case (o.outcome)
                     OUT_HANDLER:   n_handler++;
                     OUT_TERMINATE: n_terminate++;
                     default:       n_ignored++;
                  endcase
               end
            end
         end
         ACT_BLOCK, ACT_UNBLOCK, ACT_SET_MASK, ACT_RESTORE: begin
            o.mask = blk_model;
            if (r.action == ACT_BLOCK)        blk_model |= strip;
            else if (r.action == ACT_UNBLOCK) blk_model &= ~strip;
            else                              blk_model = strip;
         end
         default: begin
            if (s == 0 || r.sig == SIG_KILL || r.sig == SIG_STOP) begin
               o.status = STATUS_INVALID;
            end else begin
               o.handler  = act_handler[s];
               o.restorer = act_restorer[s];
               o.mask     = act_hmask[s];
               o.flags    = act_flags[s];
               if (r.action == ACT_WRITE_ENTRY) begin
                  act_handler[s]  = r.handler;
                  act_restorer[s] = r.restorer;
                  act_hmask[s]    = strip;
                  act_flags[s]    = {r.resethand, r.nodefer};
               end
            end
         end
      endcase
      o.blocked = blk_model;
      o.kill    = kill_seen;
      return o;
   endfunction

   // optional gap, then one item held on the request ports until taken
   task automatic send_item(input sig_req_type r, input bit gaps_on);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start             <= 1'b1;
      req_action        <= r.action;
      req_signal_number <= r.sig;
      req_mask_in       <= r.mask;
      req_handler_in    <= r.handler;
      req_restorer_in   <= r.restorer;
      req_nodefer_in    <= r.nodefer;
      req_resethand_in  <= r.resethand;
      req_task_waiting  <= r.waiting;
      req_task_is_user  <= r.is_user;
      req_user_stack    <= r.stack;
      do @(posedge clock); while (busy !== 1'b0);
      awaited_rsp.push_back(apply_signal_item(r));
      items_sent++;
   endtask

   function automatic sig_req_type make_item(input act_type a, input logic [SIG_W-1:0] s,
                                             input logic [MASK_W-1:0] m,
                                             input logic [ADDR_W-1:0] h,
                                             input logic [ADDR_W-1:0] rs,
                                             input logic nd, input logic rh,
                                             input logic w, input logic u,
                                             input logic [ADDR_W-1:0] st);
      sig_req_type r;
      r = '{action: a, sig: s, mask: m, handler: h, restorer: rs, nodefer: nd,
            resethand: rh, waiting: w, is_user: u, stack: st};
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // favours a few signals so that sends, entries and deliveries meet
   function automatic logic [SIG_W-1:0] rand_signal();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return SIG_KILL;
         2:       return SIG_STOP;
         3, 4:    return SIG_W'($urandom_range(1, 63));
         5:       return SIG_W'(1);
         6:       return SIG_W'(2);
         7:       return SIG_W'(10);
         8:       return SIG_W'(17);
         9:       return SIG_W'(28);
         default: return SIG_W'(63);
      endcase
   endfunction

   // mostly sparse, so the blocked set does not saturate
   function automatic logic [MASK_W-1:0] rand_mask();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return rand64();
         default: return (MASK_W'(1) << rand_signal()) | (MASK_W'(1) << rand_signal());
      endcase
   endfunction

   function automatic act_type rand_action();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 28)      return ACT_SEND;
      else if (p < 56) return ACT_DELIVER;
      else if (p < 62) return ACT_BLOCK;
      else if (p < 68) return ACT_UNBLOCK;
      else if (p < 73) return ACT_SET_MASK;
      else if (p < 78) return ACT_RESTORE;
      else if (p < 90) return ACT_WRITE_ENTRY;
      else             return ACT_READ_ENTRY;
   endfunction

   // every field random, including the ones the action ignores
   function automatic sig_req_type random_item(input act_type a);
      sig_req_type r;
      r.action = a;
      r.sig    = rand_signal();
      r.mask   = rand_mask();
      case ($urandom_range(0, 5))
         0:       r.handler = HANDLER_DEFAULT;
         1:       r.handler = HANDLER_IGNORE;
         2:       r.handler = '1;
         default: r.handler = rand64();
      endcase
      r.restorer  = ($urandom_range(0, 4) == 0) ? '0 : rand64();
      r.nodefer   = 1'($urandom_range(0, 1));
      r.resethand = 1'($urandom_range(0, 1));
      r.waiting   = 1'($urandom_range(0, 1));
      r.is_user   = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 5))
         0:       r.stack = ADDR_W'($urandom_range(0, 127));
         1:       r.stack = '1;
         default: r.stack = rand64();
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      sig_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            $error("response strobe with no item outstanding");
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("outcome", 64'(want.outcome), 64'(rsp_outcome));
            check_field("chosen_signal", 64'(want.chosen), 64'(rsp_chosen_signal));
            check_field("wake_task", 64'(want.wake), 64'(rsp_wake_task));
            check_field("handler_out", want.handler, rsp_handler_out);
            check_field("restorer_out", want.restorer, rsp_restorer_out);
            check_field("mask_out", want.mask, rsp_mask_out);
            check_field("flags_out", 64'(want.flags), 64'(rsp_flags_out));
            check_field("frame_stack", want.frame, rsp_frame_stack);
            check_field("termination code", 64'(want.term_code), 64'(rsp_exit_code));
            check_field("blocked_now", want.blocked, rsp_blocked_now);
            check_field("kill_requested", 64'(want.kill), 64'(rsp_kill_requested));
            rsp_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // entry reads and writes, refused entries for 0, KILL and STOP
   task automatic test_entry_access();
      send_item(make_item(ACT_READ_ENTRY, 6'd1, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0),
                1'b0);
      send_item(make_item(ACT_READ_ENTRY, 6'd0, '1, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1, '1),
                1'b0);
      send_item(make_item(ACT_WRITE_ENTRY, SIG_KILL, '0, 64'h40, 64'h80, 1'b0, 1'b0, 1'b0,
                          1'b1, '0), 1'b0);
      send_item(make_item(ACT_WRITE_ENTRY, SIG_STOP, '0, 64'h40, 64'h80, 1'b0, 1'b0, 1'b0,
                          1'b1, '0), 1'b0);
      // all-ones mask must come back without KILL and STOP
      send_item(make_item(ACT_WRITE_ENTRY, 6'd10, '1, 64'hFFFF_FFFF_FFFF_FFF0, '1,
                          1'b1, 1'b1, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_READ_ENTRY, 6'd10, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0),
                1'b0);
   endtask

   // invalid send, wake rule, default actions and KILL through a full block
   task automatic test_default_actions();
      send_item(make_item(ACT_SEND, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_SEND, 6'd17, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_DELIVER, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0), 1'b0);
      send_item(make_item(ACT_DELIVER, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_SEND, 6'd63, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_DELIVER, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_BLOCK, 6'd0, '1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_SEND, SIG_KILL, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_DELIVER, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
   endtask

   // ignore handler, missing restorer, handler run with reset-on-handle
   task automatic test_handler_delivery();
      send_item(make_item(ACT_RESTORE, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_WRITE_ENTRY, 6'd2, '0, HANDLER_IGNORE, 64'h100, 1'b0, 1'b0,
                          1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_SEND, 6'd2, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_DELIVER, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_WRITE_ENTRY, 6'd3, '0, 64'h5, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0),
                1'b0);
      send_item(make_item(ACT_SEND, 6'd3, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_DELIVER, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_SEND, 6'd10, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, '0), 1'b0);
      // stack pointer of zero makes the frame address wrap
      send_item(make_item(ACT_DELIVER, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_UNBLOCK, 6'd0, '1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_SEND, 6'd10, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, '0), 1'b0);
      send_item(make_item(ACT_DELIVER, 6'd0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, '1), 1'b0);
   endtask

   // mostly entry/send/deliver sequences on one signal, the rest loose items
   task automatic test_random_sequences(input int n, input bit with_gaps);
      sig_req_type      r;
      logic [SIG_W-1:0] s;
      int               goal;
      bit               gaps_on;
      goal    = items_sent + n;
      gaps_on = with_gaps;
      while (items_sent < goal) begin
         if (items_sent % 40 == 0) gaps_on = with_gaps && ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 9) < 6) begin
            s = rand_signal();
            r = random_item(ACT_WRITE_ENTRY);
            r.sig = s;
            send_item(r, gaps_on);
            r = random_item(ACT_SEND);
            r.sig = s;
            send_item(r, gaps_on);
            if ($urandom_range(0, 2) == 0) send_item(random_item(rand_action()), gaps_on);
            send_item(random_item(ACT_DELIVER), gaps_on);
            send_item(random_item(ACT_DELIVER), gaps_on);
            if ($urandom_range(0, 1) == 0) send_item(random_item(ACT_RESTORE), gaps_on);
         end else begin
            send_item(random_item(rand_action()), gaps_on);
         end
      end
   endtask

   // sender holds off until every outstanding response is back
   task automatic test_drain_pause();
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      send_item(random_item(ACT_DELIVER), 1'b0);
      send_item(random_item(ACT_SEND), 1'b0);
   endtask

   initial begin
      start             <= 1'b0;
      reset             <= 1'b1;
      req_action        <= ACT_SEND;
      req_signal_number <= '0;
      req_mask_in       <= '0;
      req_handler_in    <= '0;
      req_restorer_in   <= '0;
      req_nodefer_in    <= 1'b0;
      req_resethand_in  <= 1'b0;
      req_task_waiting  <= 1'b0;
      req_task_is_user  <= 1'b0;
      req_user_stack    <= '0;
      pend_model = '0;
      blk_model  = '0;
      kill_seen  = 1'b0;
      for (int i = 0; i < 64; i++) begin
         act_handler[i]  = '0;
         act_restorer[i] = '0;
         act_hmask[i]    = '0;
         act_flags[i]    = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_entry_access();
      test_default_actions();
      test_handler_delivery();
      test_random_sequences(500, 1'b1);
      test_drain_pause();
      test_random_sequences(450, 1'b1);
      // closing stretch runs back to back
      test_random_sequences(170, 1'b0);

      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (awaited_rsp.size() != 0) begin
         $error("%0d responses never arrived", awaited_rsp.size());
         fail_count++;
      end
      $display("%0d items sent, %0d responses checked, %0d wakes", items_sent, rsp_checked,
               n_wake);
      $display("deliveries: %0d handler runs, %0d terminations, %0d ignored", n_handler,
               n_terminate, n_ignored);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
